### src/bezier_adsr_envelope_level_unit_macros.svh
// assertion macros for the envelope level unit
`ifndef BEZIER_ADSR_ENVELOPE_LEVEL_UNIT_MACROS_SVH
`define BEZIER_ADSR_ENVELOPE_LEVEL_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define BAE_ASSERT_IMP(label, clk, rst_n, pre, post) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
// next-cycle implication
`define BAE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`endif

### src/bae_pkg.sv
// shared types and constants of the envelope level unit
`timescale 1ns / 1ps
`default_nettype none
package bae_pkg;
	typedef enum logic [1:0] {
		PH_ATTACK  = 2'd0,
		PH_DECAY   = 2'd1,
		PH_RELEASE = 2'd2,
		PH_OFF     = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_RELEASE = 3'd2,
		REG_START   = 3'd3,
		REG_TOP     = 3'd4,
		REG_HOLD    = 3'd5
	} reg_idx_t;

	// pipeline stage handshake
	typedef struct packed {
		logic adv;
	} stage_ctl_t;
endpackage
`default_nettype wire

### src/bae_divider.sv
// pipelined restoring divider giving the segment fraction
`timescale 1ns / 1ps
`default_nettype none
module bae_divider #(
	parameter int TB = 24,
	parameter int FB = 16,
	parameter int TAGW = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_vld,
	input  wire logic [TB-1:0]   num,
	input  wire logic [TB-1:0]   den,
	input  wire logic [TAGW-1:0] in_tag,
	output logic                 out_vld,
	output logic [FB-1:0]        quo,
	output logic [TAGW-1:0]      out_tag
);
	// one quotient bit per stage, numerator below denominator
	logic [TB:0]     rem_s  [FB+1];
	logic [TB-1:0]   den_s  [FB+1];
	logic [FB-1:0]   q_s    [FB+1];
	logic [TAGW-1:0] tag_s  [FB+1];
	logic            vld_s  [FB+1];

	always_comb begin
		rem_s[0] = {1'b0, num};
		den_s[0] = den;
		q_s[0]   = '0;
		tag_s[0] = in_tag;
		vld_s[0] = in_vld;
	end

	for (genvar k = 0; k < FB; k++) begin : g_st
		logic [TB+1:0] sh;
		logic [TB+1:0] df;
		assign sh = {rem_s[k], 1'b0};
		assign df = sh - {2'b00, den_s[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!df[TB+1]) begin
					rem_s[k+1] <= df[TB:0];
				end else begin
					rem_s[k+1] <= sh[TB:0];
				end
				q_s[k+1]   <= {q_s[k][FB-2:0], ~df[TB+1]};
				den_s[k+1] <= den_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_vld = vld_s[FB];
	assign quo     = q_s[FB];
	assign out_tag = tag_s[FB];
endmodule
`default_nettype wire

### src/bae_bezier.sv
// pipelined de casteljau evaluation with saturation
`timescale 1ns / 1ps
`default_nettype none
module bae_bezier #(
	parameter int LB = 16,
	parameter int FB = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_vld,
	input  wire logic [1:0]    in_phase,
	input  wire logic [FB-1:0] u,
	input  wire logic signed [LB+3:0] y0,
	input  wire logic signed [LB+3:0] y1,
	input  wire logic signed [LB+3:0] y2,
	input  wire logic signed [LB+3:0] y3,
	output logic               out_vld,
	output logic [1:0]         out_phase,
	output logic signed [LB-1:0] level
);
	localparam int W = LB + 4;
	localparam logic signed [W-1:0] LMAX = W'((64'sd1 <<< (LB - 1)) - 64'sd1);
	localparam logic signed [W-1:0] LMIN = -W'(64'sd1 <<< (LB - 1));

	function automatic logic signed [W-1:0] lerp(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b, input logic [FB-1:0] f);
		logic signed [W+FB+1:0] p;
		p = (b - a) * $signed({1'b0, f});
		return a + W'(p >>> FB);
	endfunction

	logic signed [W-1:0] a_s1, b_s1, c_s1, d_s2, e_s2, r_s3;
	logic [FB-1:0] u_s1, u_s2;
	logic [1:0] ph_s1, ph_s2, ph_s3;
	logic v_s1, v_s2, v_s3;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// three interpolation levels
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= lerp(y0, y1, u);
			b_s1  <= lerp(y1, y2, u);
			c_s1  <= lerp(y2, y3, u);
			u_s1  <= u;
			ph_s1 <= in_phase;
			d_s2  <= lerp(a_s1, b_s1, u_s1);
			e_s2  <= lerp(b_s1, c_s1, u_s1);
			u_s2  <= u_s1;
			ph_s2 <= ph_s1;
			r_s3  <= lerp(d_s2, e_s2, u_s2);
			ph_s3 <= ph_s2;
		end
	end

	assign out_vld   = v_s3;
	assign out_phase = ph_s3;
	assign level = (r_s3 > LMAX) ? LB'(LMAX) : (r_s3 < LMIN) ? LB'(LMIN) : LB'(r_s3);
endmodule
`default_nettype wire

### src/bezier_adsr_envelope_level_unit.sv
// Top level of the cubic bezier envelope level unit.
// Each accepted time passes phase select, the divider and the bezier stages in order.
// Throughput: one word per cycle unless the output is held; the divider stages and
// the three interpolation stages each take a new word every clock they advance.
// The whole pipeline stalls together while the output word waits.
// Reset clears the configuration registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "bezier_adsr_envelope_level_unit_macros.svh"
module bezier_adsr_envelope_level_unit #(
	parameter int TIME_BITS = 24,
	parameter int LEVEL_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic [TIME_BITS+1:0] elapsed,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [1:0] phase,
	output logic signed [LEVEL_BITS-1:0] level,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [2:0] cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int TB = TIME_BITS;
	localparam int LB = LEVEL_BITS;
	localparam int FB = FRAC_BITS;
	localparam int W  = LB + 4;
	localparam int EW = TB + 2;
	localparam logic [FB+1:0] C1 = (FB+2)'(((64'd333 << FB) + 64'd500) / 64'd1000);
	localparam logic [FB+1:0] C2 = (FB+2)'(((64'd666 << FB) + 64'd500) / 64'd1000);

	logic [TB-1:0] att_q, dec_q, rel_q;
	logic signed [LB-1:0] lo_q, hi_q;
	logic [FB-1:0] hold_q;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q <= '0; dec_q <= '0; rel_q <= '0;
			lo_q <= '0; hi_q <= '0; hold_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bae_pkg::REG_ATTACK:  att_q  <= cfg_data[TB-1:0];
				bae_pkg::REG_DECAY:   dec_q  <= cfg_data[TB-1:0];
				bae_pkg::REG_RELEASE: rel_q  <= cfg_data[TB-1:0];
				bae_pkg::REG_START:   lo_q   <= cfg_data[LB-1:0];
				bae_pkg::REG_TOP:     hi_q   <= cfg_data[LB-1:0];
				bae_pkg::REG_HOLD:    hold_q <= cfg_data[FB-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic signed [W-1:0] fmul(input logic [FB+1:0] f,
			input logic signed [W-1:0] v);
		logic signed [W+FB+2:0] p;
		p = v * $signed({1'b0, f});
		return W'(p >>> FB);
	endfunction

	// control points, registered off the configuration in two steps
	// after a register write they settle through both steps, well before a word reaches them
	logic signed [W-1:0] lo_w, hi_w, diff_w;
	logic signed [W-1:0] dd_q, sus_q, ya1_q, ya2_q, yd1_q, yd2_q, yr1_q, yr2_q;
	assign lo_w   = W'(lo_q);
	assign hi_w   = W'(hi_q);
	assign diff_w = hi_w - lo_w;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dd_q <= '0; sus_q <= '0;
			ya1_q <= '0; ya2_q <= '0;
			yd1_q <= '0; yd2_q <= '0;
			yr1_q <= '0; yr2_q <= '0;
		end else begin
			dd_q  <= fmul({2'b00, hold_q}, diff_w);
			ya1_q <= lo_w + fmul(C1, diff_w);
			ya2_q <= lo_w + fmul(C2, diff_w);
			sus_q <= lo_w + dd_q;
			yd1_q <= fmul(C2, hi_w) + fmul(C1, dd_q);
			yd2_q <= fmul(C1, hi_w) + fmul(C2, dd_q);
			yr1_q <= lo_w + fmul(C2, dd_q);
			yr2_q <= lo_w + fmul(C1, dd_q);
		end
	end

	bae_pkg::stage_ctl_t ctl;
	logic out_v;
	assign ctl.adv  = !out_valid || out_ready;
	assign in_ready = ctl.adv;

	// stage 1: phase select and offset
	logic [EW-1:0] ea, ed, er;
	logic v_s1;
	logic [1:0] ph_s1;
	logic [TB-1:0] off_s1, len_s1;
	assign ea = EW'(att_q);
	assign ed = ea + EW'(dec_q);
	assign er = ed + EW'(rel_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ctl.adv) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			if (elapsed < ea) begin
				ph_s1 <= bae_pkg::PH_ATTACK;
				off_s1 <= elapsed[TB-1:0];
				len_s1 <= att_q;
			end else if (elapsed < ed) begin
				ph_s1 <= bae_pkg::PH_DECAY;
				off_s1 <= TB'(elapsed - ea);
				len_s1 <= dec_q;
			end else if (elapsed < er) begin
				ph_s1 <= bae_pkg::PH_RELEASE;
				off_s1 <= TB'(elapsed - ed);
				len_s1 <= rel_q;
			end else begin
				ph_s1 <= bae_pkg::PH_OFF;
				off_s1 <= '0;
				len_s1 <= {{(TB-1){1'b0}}, 1'b1};
			end
		end
	end

	logic dv;
	logic [FB-1:0] uq;
	logic [1:0] dph;
	bae_divider #(.TB(TB), .FB(FB), .TAGW(2)) u_div (
		.clk(clk), .arst_n(arst_n), .en(ctl.adv), .in_vld(v_s1),
		.num(off_s1), .den(len_s1), .in_tag(ph_s1),
		.out_vld(dv), .quo(uq), .out_tag(dph)
	);

	// control point select
	logic signed [W-1:0] y0, y1, y2, y3;
	always_comb begin
		case (dph)
			bae_pkg::PH_ATTACK: begin y0 = lo_w; y1 = ya1_q; y2 = ya2_q; y3 = hi_w; end
			bae_pkg::PH_DECAY: begin y0 = hi_w; y1 = yd1_q; y2 = yd2_q; y3 = sus_q; end
			bae_pkg::PH_RELEASE: begin y0 = sus_q; y1 = yr1_q; y2 = yr2_q; y3 = lo_w; end
			default: begin y0 = lo_w; y1 = lo_w; y2 = lo_w; y3 = lo_w; end
		endcase
	end

	bae_bezier #(.LB(LB), .FB(FB)) u_bez (
		.clk(clk), .arst_n(arst_n), .en(ctl.adv), .in_vld(dv), .in_phase(dph),
		.u(uq), .y0(y0), .y1(y1), .y2(y2), .y3(y3),
		.out_vld(out_v), .out_phase(phase), .level(level)
	);
	assign out_valid = out_v;

	`BAE_ASSERT_NEXT(a_hold_word, clk, arst_n, out_valid && !out_ready, out_valid && $stable(level))
	`BAE_ASSERT_IMP(a_ready, clk, arst_n, out_valid && !out_ready, !in_ready)
	`BAE_ASSERT_IMP(a_off_level, clk, arst_n, out_valid && phase == bae_pkg::PH_OFF, level == lo_q)
endmodule
`default_nettype wire

### sim/tb_bezier_adsr_envelope_level_unit.sv
// testbench for the bezier envelope level unit: directed table, random sweeps, level predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_bezier_adsr_envelope_level_unit;
	localparam int TB_TIME = 24;
	localparam int TB_LEVEL = 16;
	localparam int TB_FRAC = 16;
	localparam int PIPE_LAT = TB_FRAC + 6;
	localparam longint K_THIRD = ((333 << TB_FRAC) + 500) / 1000;
	localparam longint K_TWO_THIRDS = ((666 << TB_FRAC) + 500) / 1000;
	localparam longint LVL_MAX = (64'sd1 << (TB_LEVEL - 1)) - 1;
	localparam longint LVL_MIN = -(64'sd1 << (TB_LEVEL - 1));
	localparam int IDLE_LIMIT = 20000;
	localparam int N_RANDOM = 1900;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [TB_TIME+1:0] elapsed;
	logic out_valid;
	logic out_ready;
	logic [1:0] phase;
	logic signed [TB_LEVEL-1:0] level;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	bezier_adsr_envelope_level_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .elapsed(elapsed),
		.out_valid(out_valid), .out_ready(out_ready), .phase(phase), .level(level),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	typedef struct {
		bae_pkg::phase_t ph;
		logic signed [TB_LEVEL-1:0] lvl;
	} env_word_t;

	// shadow copy of the envelope registers
	logic [TB_TIME-1:0] sh_attack, sh_decay, sh_release;
	logic signed [TB_LEVEL-1:0] sh_start, sh_top;
	logic [TB_FRAC-1:0] sh_hold;

	env_word_t pending_words[$];
	int errors = 0;
	int idle_cycles = 0;
	bit long_hold = 0;
	bit sink_enable = 0;

	// clock
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint fshift(longint x);
		return x >>> TB_FRAC;
	endfunction

	function automatic longint mix(longint a, longint b, longint u);
		return a + fshift((b - a) * u);
	endfunction

	function automatic longint curve(longint y0, longint y1, longint y2, longint y3, longint u);
		longint a, b, c, d, e;
		a = mix(y0, y1, u);
		b = mix(y1, y2, u);
		c = mix(y2, y3, u);
		d = mix(a, b, u);
		e = mix(b, c, u);
		return mix(d, e, u);
	endfunction

	function automatic longint seg_frac(longint off, longint len);
		if (len == 0)
			return 0;
		return ((off << TB_FRAC) / len) & ((64'd1 << TB_FRAC) - 1);
	endfunction

	// expected phase and level for one elapsed time
	function automatic env_word_t envelope_at(logic [TB_TIME+1:0] t_in);
		env_word_t w;
		longint t, ea, ed, er, lo, hi, df, dd, sus, lv, u;
		t = t_in;
		ea = sh_attack;
		ed = ea + sh_decay;
		er = ed + sh_release;
		lo = sh_start;
		hi = sh_top;
		df = hi - lo;
		dd = fshift(longint'(sh_hold) * df);
		sus = lo + dd;
		if (t < ea) begin
			u = seg_frac(t, sh_attack);
			w.ph = bae_pkg::PH_ATTACK;
			lv = curve(lo, lo + fshift(K_THIRD * df), lo + fshift(K_TWO_THIRDS * df), hi, u);
		end else if (t < ed) begin
			u = seg_frac(t - ea, sh_decay);
			w.ph = bae_pkg::PH_DECAY;
			lv = curve(hi, fshift(K_TWO_THIRDS * hi) + fshift(K_THIRD * dd),
				fshift(K_THIRD * hi) + fshift(K_TWO_THIRDS * dd), sus, u);
		end else if (t < er) begin
			u = seg_frac(t - ed, sh_release);
			w.ph = bae_pkg::PH_RELEASE;
			lv = curve(sus, lo + fshift(K_TWO_THIRDS * dd), lo + fshift(K_THIRD * dd), lo, u);
		end else begin
			w.ph = bae_pkg::PH_OFF;
			lv = lo;
		end
		if (lv > LVL_MAX)
			lv = LVL_MAX;
		if (lv < LVL_MIN)
			lv = LVL_MIN;
		w.lvl = lv[TB_LEVEL-1:0];
		return w;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// register write while the unit is idle
	task automatic write_reg(input bae_pkg::reg_idx_t idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			bae_pkg::REG_ATTACK: sh_attack = val[TB_TIME-1:0];
			bae_pkg::REG_DECAY: sh_decay = val[TB_TIME-1:0];
			bae_pkg::REG_RELEASE: sh_release = val[TB_TIME-1:0];
			bae_pkg::REG_START: sh_start = val[TB_LEVEL-1:0];
			bae_pkg::REG_TOP: sh_top = val[TB_LEVEL-1:0];
			bae_pkg::REG_HOLD: sh_hold = val[TB_FRAC-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] a, d, r, s, p, h);
		write_reg(bae_pkg::REG_ATTACK, a);
		write_reg(bae_pkg::REG_DECAY, d);
		write_reg(bae_pkg::REG_RELEASE, r);
		write_reg(bae_pkg::REG_START, s);
		write_reg(bae_pkg::REG_TOP, p);
		write_reg(bae_pkg::REG_HOLD, h);
	endtask

	// offer one word and hold it until taken
	task automatic send_time(input logic [TB_TIME+1:0] t);
		elapsed <= t;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		pending_words.push_back(envelope_at(t));
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
	endtask

	// random time biased towards the configured segments
	function automatic logic [TB_TIME+1:0] pick_time();
		longint span;
		span = longint'(sh_attack) + sh_decay + sh_release;
		case ($urandom_range(0, 9))
			0: return (TB_TIME+2)'($urandom());
			1: return (TB_TIME+2)'(span + $urandom_range(0, 3));
			2: return (span == 0) ? '0 : (TB_TIME+2)'(span - 1);
			default: return (span == 0) ? (TB_TIME+2)'($urandom_range(0, 7))
				: (TB_TIME+2)'(longint'($urandom()) % (span + 2));
		endcase
	endfunction

	function automatic logic [TB_TIME-1:0] pick_len();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return TB_TIME'({TB_TIME{1'b1}} - $urandom_range(0, 3));
			2: return TB_TIME'($urandom_range(1, 4));
			3: return TB_TIME'($urandom());
			default: return TB_TIME'($urandom_range(1, 5000));
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		env_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word phase", phase, -1);
			end else begin
				want = pending_words.pop_front();
				if (phase !== want.ph)
					report_mismatch("phase", phase, want.ph);
				if (level !== want.lvl)
					report_mismatch("level", level, want.lvl);
			end
		end
	end

	// receiver stall pattern, with one long hold-off on request
	initial begin
		int hold_n;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 0;
				repeat (200) @(posedge clk);
				long_hold = 0;
			end else if (!sink_enable) begin
				out_ready <= 1;
			end else begin
				hold_n = $urandom_range(0, 3);
				out_ready <= (hold_n != 0);
			end
		end
	end

	// watchdog on stalled handshakes
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	typedef struct {
		logic [TB_TIME+1:0] t;
		bit fixed;
		bae_pkg::phase_t ph;
		logic signed [TB_LEVEL-1:0] lvl;
	} stim_row_t;

	stim_row_t dir_rows[$];

	initial begin
		int burst, gap;
		env_word_t w;
		in_valid <= 0;
		elapsed <= '0;
		cfg_valid <= 0;
		cfg_index <= bae_pkg::REG_ATTACK;
		cfg_data <= '0;
		sh_attack = 0; sh_decay = 0; sh_release = 0;
		sh_start = 0; sh_top = 0; sh_hold = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// after reset every segment is empty: off at level zero
		dir_rows.push_back('{0, 1, bae_pkg::PH_OFF, 0});
		dir_rows.push_back('{{(TB_TIME+2){1'b1}}, 1, bae_pkg::PH_OFF, 0});
		foreach (dir_rows[i]) begin
			send_time(dir_rows[i].t);
			if (dir_rows[i].fixed) begin
				pending_words.pop_back();
				w.ph = dir_rows[i].ph;
				w.lvl = dir_rows[i].lvl;
				pending_words.push_back(w);
			end
		end
		drain();

		// full-scale rise, extreme times and saturation corners
		write_all(100, 50, 80, 32'hFFFF8000, 32'h7FFF, 32'hFFFF);
		dir_rows.delete();
		dir_rows.push_back('{0, 1, bae_pkg::PH_ATTACK, -32768});
		dir_rows.push_back('{99, 0, bae_pkg::PH_ATTACK, 0});
		dir_rows.push_back('{100, 1, bae_pkg::PH_DECAY, 32767});
		dir_rows.push_back('{149, 0, bae_pkg::PH_DECAY, 0});
		dir_rows.push_back('{150, 0, bae_pkg::PH_RELEASE, 0});
		dir_rows.push_back('{229, 0, bae_pkg::PH_RELEASE, 0});
		dir_rows.push_back('{230, 1, bae_pkg::PH_OFF, -32768});
		dir_rows.push_back('{{(TB_TIME+2){1'b1}}, 1, bae_pkg::PH_OFF, -32768});
		foreach (dir_rows[i]) begin
			send_time(dir_rows[i].t);
			if (dir_rows[i].fixed) begin
				pending_words.pop_back();
				w.ph = dir_rows[i].ph;
				w.lvl = dir_rows[i].lvl;
				pending_words.push_back(w);
			end
		end
		drain();

		// falling envelope, maximum segment lengths, top bits of data ignored
		write_all(32'hFFFFFFFF, 32'hFFFFFF, 1, 32'h12347FFF, 32'hABCD8000, 32'h5555_0000);
		for (int i = 0; i < 8; i++)
			send_time(i < 4 ? 26'(26'h3FFFFFF - i) : 26'(26'hFFFFFF + i));
		send_time(26'h1FFFFFD);
		send_time(26'h1FFFFFE);
		drain();

		// random phases, each with fresh settings
		sink_enable = 1;
		for (int n = 0; n < N_RANDOM; ) begin
			write_all(pick_len(), pick_len(), pick_len(), $urandom(), $urandom(),
				($urandom_range(0, 4) == 0) ? 32'hFFFF : $urandom());
			if (n == 400)
				long_hold = 1;
			for (int k = 0; k < 100 && n < N_RANDOM; ) begin
				burst = $urandom_range(1, 20);
				for (int b = 0; b < burst; b++) begin
					send_time(pick_time());
					k++;
					n++;
				end
				gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					in_valid <= 0;
					repeat (gap) @(posedge clk);
				end
			end
			drain();
		end

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
